>>> hw/rtl/wall_follow_pid_steer_assert.svh
// Assertion macros shared by the wall follower checks.
`ifndef WALL_FOLLOW_PID_STEER_ASSERT_SVH
`define WALL_FOLLOW_PID_STEER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define WFPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wall_follow_pid_steer check failed");

// next-cycle implication
`define WFPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wall_follow_pid_steer check failed");

`endif

>>> hw/rtl/wfps_pkg.sv
// Types, constants and register map of the wall follower steering block.
`timescale 1ns / 1ps

package wfps_pkg;

	localparam int SAMPLE_W        = 10;
	localparam int SENSOR_BITS_DEF = 10;
	localparam int SUM_W           = 24;
	localparam int SPEED_W         = 9;
	localparam int GAIN_W          = 12;
	localparam int BASE_W          = 8;
	localparam int ADDR_W          = 5;
	localparam int DATA_W          = 32;

	localparam logic [BASE_W-1:0]          RST_BASE_SPEED  = 8'd100;
	localparam logic signed [GAIN_W-1:0]   RST_GAIN_P      = 12'sd179;
	localparam logic signed [GAIN_W-1:0]   RST_GAIN_I      = 12'sd0;
	localparam logic signed [GAIN_W-1:0]   RST_GAIN_D      = 12'sd230;
	localparam logic [SAMPLE_W-1:0]        RST_FRONT_LIMIT = 10'd55;
	localparam logic                       RST_LEFT_WALL   = 1'b1;
	localparam logic [SAMPLE_W-1:0]        RST_SIDE_TARGET = 10'd0;

	typedef enum logic [2:0] {
		REG_BASE_SPEED  = 3'd0,
		REG_GAIN_P      = 3'd1,
		REG_GAIN_I      = 3'd2,
		REG_GAIN_D      = 3'd3,
		REG_FRONT_LIMIT = 3'd4,
		REG_LEFT_WALL   = 3'd5,
		REG_SIDE_TARGET = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [BASE_W-1:0]        base_speed;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [SAMPLE_W-1:0]      front_limit;
		logic                     left_wall;
		logic [SAMPLE_W-1:0]      side_target;
	} cfg_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left;
		logic signed [SPEED_W-1:0] right;
		logic                      turning;
		logic                      upd;
		logic signed [SUM_W-1:0]   esum_nxt;
	} pid_res_t;

endpackage

>>> hw/rtl/wfps_regs.sv
// APB register file holding the steering configuration.
`timescale 1ns / 1ps

module wfps_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wfps_pkg::ADDR_W-1:0]   paddr,
	input  logic [wfps_pkg::DATA_W-1:0]   pwdata,
	output logic [wfps_pkg::DATA_W-1:0]   prdata,
	output wfps_pkg::cfg_t                cfg
);

	wfps_pkg::cfg_t      cfg_q;
	wfps_pkg::reg_idx_t  idx;
	logic                wr_en;

	assign idx   = wfps_pkg::reg_idx_t'(paddr[wfps_pkg::ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_speed  <= wfps_pkg::RST_BASE_SPEED;
			cfg_q.gain_p      <= wfps_pkg::RST_GAIN_P;
			cfg_q.gain_i      <= wfps_pkg::RST_GAIN_I;
			cfg_q.gain_d      <= wfps_pkg::RST_GAIN_D;
			cfg_q.front_limit <= wfps_pkg::RST_FRONT_LIMIT;
			cfg_q.left_wall   <= wfps_pkg::RST_LEFT_WALL;
			cfg_q.side_target <= wfps_pkg::RST_SIDE_TARGET;
		end else if (wr_en) begin
			unique case (idx)
				wfps_pkg::REG_BASE_SPEED:  cfg_q.base_speed  <= pwdata[7:0];
				wfps_pkg::REG_GAIN_P:      cfg_q.gain_p      <= $signed(pwdata[11:0]);
				wfps_pkg::REG_GAIN_I:      cfg_q.gain_i      <= $signed(pwdata[11:0]);
				wfps_pkg::REG_GAIN_D:      cfg_q.gain_d      <= $signed(pwdata[11:0]);
				wfps_pkg::REG_FRONT_LIMIT: cfg_q.front_limit <= pwdata[9:0];
				wfps_pkg::REG_LEFT_WALL:   cfg_q.left_wall   <= pwdata[0];
				wfps_pkg::REG_SIDE_TARGET: cfg_q.side_target <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// gains read back sign-extended
	always_comb begin
		unique case (idx)
			wfps_pkg::REG_BASE_SPEED:  prdata = {24'd0, cfg_q.base_speed};
			wfps_pkg::REG_GAIN_P:      prdata = {{20{cfg_q.gain_p[11]}}, cfg_q.gain_p};
			wfps_pkg::REG_GAIN_I:      prdata = {{20{cfg_q.gain_i[11]}}, cfg_q.gain_i};
			wfps_pkg::REG_GAIN_D:      prdata = {{20{cfg_q.gain_d[11]}}, cfg_q.gain_d};
			wfps_pkg::REG_FRONT_LIMIT: prdata = {22'd0, cfg_q.front_limit};
			wfps_pkg::REG_LEFT_WALL:   prdata = {31'd0, cfg_q.left_wall};
			wfps_pkg::REG_SIDE_TARGET: prdata = {22'd0, cfg_q.side_target};
			default:                   prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/wfps_core.sv
// PID correction, turn decision and speed saturation for one sample.
`timescale 1ns / 1ps

module wfps_core (
	input  wfps_pkg::cfg_t                      cfg,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       side,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       front,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       target,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       last_side,
	input  logic signed [wfps_pkg::SUM_W-1:0]   esum,
	input  logic                                in_turn,
	output wfps_pkg::pid_res_t                  res
);

	localparam int SW  = wfps_pkg::SAMPLE_W;
	localparam int EW  = wfps_pkg::SUM_W;
	localparam int GW  = wfps_pkg::GAIN_W;
	localparam int VW  = wfps_pkg::SPEED_W;
	localparam int PPW = GW + SW + 1;          // gain * error
	localparam int PIW = GW + EW;              // gain * sum
	localparam int TW  = PIW + 1;              // total of three products
	localparam int QW  = TW - 8;               // after divide by 256
	localparam int LW  = QW + 1;               // base +/- correction

	localparam logic signed [EW-1:0] SUM_MAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0] SUM_MIN = {1'b1, {(EW-1){1'b0}}};
	localparam logic signed [VW-1:0] SPD_MAX = VW'(255);
	localparam logic signed [VW-1:0] SPD_MIN = -SPD_MAX;

	logic                    blocked;
	logic signed [SW:0]      p_err;
	logic signed [SW:0]      d_err;
	logic signed [EW:0]      acc;
	logic signed [EW-1:0]    esum_sat;
	logic signed [PPW-1:0]   prod_p;
	logic signed [PIW-1:0]   prod_i;
	logic signed [PPW-1:0]   prod_d;
	logic signed [TW-1:0]    total;
	logic signed [TW-1:0]    total_adj;
	logic signed [QW-1:0]    pid;
	logic signed [LW-1:0]    base_ext;
	logic signed [LW-1:0]    plus_sum;
	logic signed [LW-1:0]    minus_sum;
	logic signed [VW-1:0]    plus_sat;
	logic signed [VW-1:0]    minus_sat;
	logic signed [VW-1:0]    pivot_pos;
	logic signed [VW-1:0]    pivot_neg;

	function automatic logic signed [VW-1:0] sat_speed(input logic signed [LW-1:0] v);
		logic signed [VW-1:0] r;
		if (v > LW'(SPD_MAX))
			r = SPD_MAX;
		else if (v < LW'(SPD_MIN))
			r = SPD_MIN;
		else
			r = v[VW-1:0];
		return r;
	endfunction

	always_comb begin
		blocked = front > cfg.front_limit;

		p_err = $signed({1'b0, side}) - $signed({1'b0, target});
		d_err = $signed({1'b0, side}) - $signed({1'b0, last_side});

		acc = {esum[EW-1], esum} + {{(EW-SW){p_err[SW]}}, p_err};
		if (acc[EW] != acc[EW-1])
			esum_sat = acc[EW] ? SUM_MIN : SUM_MAX;
		else
			esum_sat = acc[EW-1:0];

		prod_p = cfg.gain_p * p_err;
		prod_i = cfg.gain_i * esum_sat;
		prod_d = cfg.gain_d * d_err;
		total  = prod_p + prod_i + prod_d;

		// divide by 256 rounding toward zero
		total_adj = total + (total[TW-1] ? TW'(255) : TW'(0));
		pid       = total_adj[TW-1:8];

		base_ext  = $signed({{(LW-wfps_pkg::BASE_W){1'b0}}, cfg.base_speed});
		plus_sum  = base_ext + pid;
		minus_sum = base_ext - pid;
		plus_sat  = sat_speed(plus_sum);
		minus_sat = sat_speed(minus_sum);

		pivot_pos = $signed({1'b0, cfg.base_speed});
		pivot_neg = -pivot_pos;

		if (blocked) begin
			res.left  = cfg.left_wall ? pivot_pos : pivot_neg;
			res.right = cfg.left_wall ? pivot_neg : pivot_pos;
		end else begin
			res.left  = cfg.left_wall ? plus_sat : minus_sat;
			res.right = cfg.left_wall ? minus_sat : plus_sat;
		end
		res.turning  = blocked;
		// mid-turn samples leave the PID state alone
		res.upd      = !(in_turn && blocked);
		res.esum_nxt = esum_sat;
	end

endmodule

>>> hw/rtl/wall_follow_pid_steer.sv
// Wall-following PID steering for a differential drive: top level.
// Takes one side/front sample word per cycle while sample_ready is high and gives one
// speed word per sample. The sample register feeds the PID stage (three multiplies,
// sum, divide by 256, saturation), which loads the output register. Throughput is one
// sample per clock unless the output stalls, set by the PID stage, which updates
// error_sum and last_side in the same cycle so the next sample sees them at once.
// Readings are masked to SENSOR_BITS bits (at most 10 take effect). Configuration
// sits on an APB port, registers at byte addresses 4*i; write it only while idle.
`timescale 1ns / 1ps

module wall_follow_pid_steer #(
	parameter int SENSOR_BITS = wfps_pkg::SENSOR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wfps_pkg::ADDR_W-1:0]         paddr,
	input  logic [wfps_pkg::DATA_W-1:0]         pwdata,
	output logic [wfps_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       side_sample,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       front_sample,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	output logic signed [wfps_pkg::SPEED_W-1:0] left_speed,
	output logic signed [wfps_pkg::SPEED_W-1:0] right_speed,
	output logic                                turning,
	output logic                                speed_valid,
	input  logic                                speed_ready
);

	localparam int SW       = wfps_pkg::SAMPLE_W;
	localparam int EFF_BITS = (SENSOR_BITS < SW) ? SENSOR_BITS : SW;
	localparam logic [SW-1:0] SENS_MASK = {SW{1'b1}} >> (SW - EFF_BITS);

	wfps_pkg::cfg_t                       cfg;
	wfps_pkg::pid_res_t                   res;

	logic                                 valid_s1;
	logic [SW-1:0]                        side_s1;
	logic [SW-1:0]                        front_s1;
	logic signed [wfps_pkg::SUM_W-1:0]    esum_q;
	logic [EFF_BITS-1:0]                  last_side_q;
	logic                                 in_turn_q;
	logic signed [wfps_pkg::SPEED_W-1:0]  left_q;
	logic signed [wfps_pkg::SPEED_W-1:0]  right_q;
	logic                                 turning_q;
	logic                                 out_valid_q;
	logic                                 adv;
	logic                                 fire;

	assign pready       = 1'b1;
	assign adv          = !out_valid_q || speed_ready;
	assign fire         = valid_s1 && adv;
	assign sample_ready = !valid_s1 || adv;

	assign left_speed   = left_q;
	assign right_speed  = right_q;
	assign turning      = turning_q;
	assign speed_valid  = out_valid_q;

	wfps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	wfps_core u_core (
		.cfg       (cfg),
		.side      (side_s1),
		.front     (front_s1),
		.target    (cfg.side_target & SENS_MASK),
		.last_side (SW'(last_side_q)),
		.esum      (esum_q),
		.in_turn   (in_turn_q),
		.res       (res)
	);

	// sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			side_s1  <= side_sample & SENS_MASK;
			front_s1 <= front_sample & SENS_MASK;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q      <= '0;
			last_side_q <= '0;
			in_turn_q   <= 1'b0;
		end else if (fire) begin
			if (res.upd) begin
				esum_q      <= res.esum_nxt;
				last_side_q <= side_s1[EFF_BITS-1:0];
			end
			in_turn_q <= res.turning;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			left_q    <= res.left;
			right_q   <= res.right;
			turning_q <= res.turning;
		end
	end

endmodule

>>> hw/rtl/wfps_checker.sv
// Port-level checks for the wall follower, bound to the top level.
`timescale 1ns / 1ps
`include "wall_follow_pid_steer_assert.svh"

module wfps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                sample_valid,
	input logic                                sample_ready,
	input logic signed [wfps_pkg::SPEED_W-1:0] left_speed,
	input logic signed [wfps_pkg::SPEED_W-1:0] right_speed,
	input logic                                turning,
	input logic                                speed_valid,
	input logic                                speed_ready
);

	// pivot words spin the wheels in opposite directions at equal speed
	`WFPS_ASSERT_IMP(a_pivot_sym, speed_valid && turning, (left_speed + right_speed) == 9'd0)

	// saturation never lets -256 through
	`WFPS_ASSERT_IMP(a_no_min, speed_valid, left_speed != 9'h100 && right_speed != 9'h100)

	// with no word waiting on the output, a sample can always come in
	`WFPS_ASSERT_IMP(a_ready_free, !speed_valid, sample_ready)

	`WFPS_ASSERT_NXT(a_out_hold, speed_valid && !speed_ready,
		speed_valid && $stable(left_speed) && $stable(right_speed) && $stable(turning))

endmodule

bind wall_follow_pid_steer wfps_checker u_wfps_checker (.*);

>>> tb/sv/wall_follow_pid_steer_checker.sv
// Checker for the wall follower steering block: tracks config, predicts speed words, compares.
`timescale 1ns / 1ps

module wall_follow_pid_steer_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wfps_pkg::ADDR_W-1:0]         paddr,
	input  logic [wfps_pkg::DATA_W-1:0]         pwdata,
	input  logic                                pready,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       side_sample,
	input  logic [wfps_pkg::SAMPLE_W-1:0]       front_sample,
	input  logic                                sample_valid,
	input  logic                                sample_ready,
	input  logic signed [wfps_pkg::SPEED_W-1:0] left_speed,
	input  logic signed [wfps_pkg::SPEED_W-1:0] right_speed,
	input  logic                                turning,
	input  logic                                speed_valid,
	input  logic                                speed_ready,
	output int                                  fail_count,
	output int                                  pending_words
);

	localparam longint ESUM_MAX  = (longint'(1) <<< (wfps_pkg::SUM_W - 1)) - 1;
	localparam longint ESUM_MIN  = -ESUM_MAX - 1;
	localparam longint SPEED_LIM = 255;

	typedef struct packed {
		logic signed [wfps_pkg::SPEED_W-1:0] left;
		logic signed [wfps_pkg::SPEED_W-1:0] right;
		logic                                turning;
	} speed_word_t;

	speed_word_t speed_q[$];

	// shadow of the register file
	logic [wfps_pkg::BASE_W-1:0]          base_spd;
	logic signed [wfps_pkg::GAIN_W-1:0]   kp, ki, kd;
	logic [wfps_pkg::SAMPLE_W-1:0]        front_lim;
	logic                                 fol_left;
	logic [wfps_pkg::SAMPLE_W-1:0]        side_tgt;

	// controller state
	longint                               err_sum;
	logic [wfps_pkg::SAMPLE_W-1:0]        prev_side;
	logic                                 turn_active;

	int fails;
	int shown;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic speed_word_t steer_predict(input logic [wfps_pkg::SAMPLE_W-1:0] side,
			input logic [wfps_pkg::SAMPLE_W-1:0] front);
		speed_word_t w;
		logic        blocked;
		longint      base, p, d, pid, l, r;
		blocked = front > front_lim;
		base = longint'(base_spd);
		l = 0;
		r = 0;
		// a pivot already under way freezes the PID state
		if (!(turn_active && blocked)) begin
			p = longint'(side) - longint'(side_tgt);
			d = longint'(side) - longint'(prev_side);
			err_sum = clip(err_sum + p, ESUM_MIN, ESUM_MAX);
			prev_side = side;
			pid = (longint'(kp) * p + longint'(ki) * err_sum + longint'(kd) * d) / 256;
			if (fol_left) begin
				l = base + pid;
				r = base - pid;
			end else begin
				l = base - pid;
				r = base + pid;
			end
			l = clip(l, -SPEED_LIM, SPEED_LIM);
			r = clip(r, -SPEED_LIM, SPEED_LIM);
		end
		if (blocked) begin
			l = fol_left ? base : -base;
			r = fol_left ? -base : base;
		end
		turn_active = blocked;
		w.left = l[wfps_pkg::SPEED_W-1:0];
		w.right = r[wfps_pkg::SPEED_W-1:0];
		w.turning = blocked;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		speed_word_t got;
		speed_word_t want;
		if (!arst_n) begin
			base_spd = wfps_pkg::RST_BASE_SPEED;
			kp = wfps_pkg::RST_GAIN_P;
			ki = wfps_pkg::RST_GAIN_I;
			kd = wfps_pkg::RST_GAIN_D;
			front_lim = wfps_pkg::RST_FRONT_LIMIT;
			fol_left = wfps_pkg::RST_LEFT_WALL;
			side_tgt = wfps_pkg::RST_SIDE_TARGET;
			err_sum = 0;
			prev_side = '0;
			turn_active = 1'b0;
			fails = 0;
			shown = 0;
			speed_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[wfps_pkg::ADDR_W-1:2])
					wfps_pkg::REG_BASE_SPEED:  base_spd = pwdata[wfps_pkg::BASE_W-1:0];
					wfps_pkg::REG_GAIN_P:      kp = pwdata[wfps_pkg::GAIN_W-1:0];
					wfps_pkg::REG_GAIN_I:      ki = pwdata[wfps_pkg::GAIN_W-1:0];
					wfps_pkg::REG_GAIN_D:      kd = pwdata[wfps_pkg::GAIN_W-1:0];
					wfps_pkg::REG_FRONT_LIMIT: front_lim = pwdata[wfps_pkg::SAMPLE_W-1:0];
					wfps_pkg::REG_LEFT_WALL:   fol_left = pwdata[0];
					wfps_pkg::REG_SIDE_TARGET: side_tgt = pwdata[wfps_pkg::SAMPLE_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && sample_ready)
				speed_q.push_back(steer_predict(side_sample, front_sample));
			if (speed_valid && speed_ready) begin
				got = {left_speed, right_speed, turning};
				if (speed_q.size() == 0) begin
					fails++;
					if (shown < 10)
						$display("speed word with none expected: left %0d right %0d turning %0b",
							got.left, got.right, got.turning);
					shown++;
				end else begin
					want = speed_q.pop_front();
					if (got !== want) begin
						fails++;
						if (shown < 10)
							$display("speed mismatch: exp %0d %0d %0b, got %0d %0d %0b",
								want.left, want.right, want.turning,
								got.left, got.right, got.turning);
						shown++;
					end
				end
			end
		end
		fail_count <= fails;
		pending_words <= speed_q.size();
	end

endmodule

>>> tb/sv/wall_follow_pid_steer_tb.sv
// Testbench top for the wall follower steering block: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module wall_follow_pid_steer_tb;

	localparam int         SW           = wfps_pkg::SAMPLE_W;
	localparam int         BW           = wfps_pkg::BASE_W;
	localparam int         GW           = wfps_pkg::GAIN_W;
	localparam int         DW           = wfps_pkg::DATA_W;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;
	localparam longint     CYCLE_LIMIT  = 500000;
	localparam int         HOLD_CYCLES  = 200;
	localparam int         PHASES       = 9;
	localparam int         PHASE_WORDS  = 130;
	localparam int         SOAK_UP      = 80;
	localparam int         SOAK_DOWN    = 80;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [wfps_pkg::ADDR_W-1:0]         paddr;
	logic [DW-1:0]                       pwdata;
	logic [DW-1:0]                       prdata;
	logic                                pready;
	logic [SW-1:0]                       side_sample;
	logic [SW-1:0]                       front_sample;
	logic                                sample_valid;
	logic                                sample_ready;
	logic signed [wfps_pkg::SPEED_W-1:0] left_speed;
	logic signed [wfps_pkg::SPEED_W-1:0] right_speed;
	logic                                turning;
	logic                                speed_valid;
	logic                                speed_ready;

	int     fail_count;
	int     pending_words;
	longint cycles = 0;
	bit     burst;
	bit     hold_req;
	logic [SW-1:0] cur_lim;
	logic [SW-1:0] cur_tgt;

	wall_follow_pid_steer dut (.*);

	wall_follow_pid_steer_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_sample(input logic [SW-1:0] s, input logic [SW-1:0] f);
		int gap;
		gap = burst ? 0 : int'($urandom_range(0, 8));
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		side_sample <= s;
		front_sample <= f;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
	endtask

	// stop offering and wait until every predicted word has come back
	task automatic drain_results();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// kind 0: every register at its low end, kind 1: high end, else random
	task automatic apply_setting(input int kind);
		logic [31:0]   junk;
		logic [BW-1:0] base;
		logic [GW-1:0] gp, gi, gd;
		logic [SW-1:0] lim, tgt;
		logic          fl;
		junk = $urandom();
		if (kind == 0) begin
			base = '0;
			gp = 12'h800;
			gi = 12'h800;
			gd = 12'h800;
			lim = '0;
			fl = 1'b0;
			tgt = '0;
		end else if (kind == 1) begin
			base = 8'hFF;
			gp = 12'h7FF;
			gi = 12'h7FF;
			gd = 12'h7FF;
			lim = 10'h3FF;
			fl = 1'b1;
			tgt = 10'h3FF;
		end else begin
			base = BW'($urandom());
			// modest gains mostly, so speeds do not sit on the rails
			gp = ($urandom_range(0, 3) == 0) ? GW'($urandom())
				: GW'($urandom_range(0, 511) - 256);
			gi = ($urandom_range(0, 3) == 0) ? GW'($urandom())
				: GW'($urandom_range(0, 15) - 8);
			gd = ($urandom_range(0, 3) == 0) ? GW'($urandom())
				: GW'($urandom_range(0, 511) - 256);
			lim = ($urandom_range(0, 3) == 0) ? SW'($urandom())
				: SW'($urandom_range(100, 900));
			fl = ($urandom_range(0, 1) != 0);
			tgt = SW'($urandom());
		end
		cur_lim = lim;
		cur_tgt = tgt;
		reg_write(wfps_pkg::REG_BASE_SPEED, {junk[31:BW], base});
		reg_write(wfps_pkg::REG_GAIN_P, {junk[31:GW], gp});
		reg_write(wfps_pkg::REG_GAIN_I, {junk[GW-1:0], junk[31:24], gi});
		reg_write(wfps_pkg::REG_GAIN_D, {~junk[31:GW], gd});
		reg_write(wfps_pkg::REG_FRONT_LIMIT, {junk[31:SW], lim});
		reg_write(wfps_pkg::REG_LEFT_WALL, {junk[31:1], fl});
		reg_write(wfps_pkg::REG_SIDE_TARGET, {~junk[31:SW], tgt});
	endtask

	initial begin
		int            turn_left;
		int            near;
		logic [SW-1:0] s;
		logic [SW-1:0] f;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		side_sample = '0;
		front_sample = '0;
		sample_valid = 1'b0;
		burst = 1'b0;
		hold_req = 1'b0;
		turn_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: normal, turn entry, held turn, clear at the limit
		send_sample(10'd0, 10'd0);
		send_sample(10'h3FF, 10'd0);
		send_sample(10'h3FF, 10'h3FF);
		send_sample(10'd0, 10'h3FF);
		send_sample(10'd700, 10'd56);
		send_sample(10'd700, 10'd55);
		send_sample(10'd0, 10'd0);
		drain_results();

		// right wall, extreme gains, zero limit
		reg_write(wfps_pkg::REG_BASE_SPEED, 32'd255);
		reg_write(wfps_pkg::REG_GAIN_P, 32'h7FF);
		reg_write(wfps_pkg::REG_GAIN_I, 32'hFFFF_F800);
		reg_write(wfps_pkg::REG_GAIN_D, 32'h800);
		reg_write(wfps_pkg::REG_FRONT_LIMIT, 32'd0);
		reg_write(wfps_pkg::REG_LEFT_WALL, 32'd0);
		reg_write(wfps_pkg::REG_SIDE_TARGET, 32'h3FF);
		send_sample(10'd0, 10'd0);
		send_sample(10'h3FF, 10'd1);
		send_sample(10'd512, 10'd1);
		send_sample(10'h3FF, 10'd0);
		send_sample(10'd0, 10'd0);
		drain_results();

		// tiny gain: -1/256 has to truncate to zero; front at max never blocks
		reg_write(wfps_pkg::REG_BASE_SPEED, 32'd0);
		reg_write(wfps_pkg::REG_GAIN_P, 32'd1);
		reg_write(wfps_pkg::REG_GAIN_I, 32'd0);
		reg_write(wfps_pkg::REG_GAIN_D, 32'd0);
		reg_write(wfps_pkg::REG_FRONT_LIMIT, 32'h3FF);
		reg_write(wfps_pkg::REG_LEFT_WALL, 32'd1);
		reg_write(wfps_pkg::REG_SIDE_TARGET, 32'd1);
		reg_write(REG_UNMAPPED, $urandom());
		send_sample(10'd0, 10'h3FF);
		send_sample(10'd0, 10'h3FF);
		send_sample(10'd2, 10'd0);
		send_sample(10'd1, 10'h3FF);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			apply_setting(ph);
			burst = (ph % 3 == 2);
			// receiver stalls long while words keep coming, so the pipe backs up
			if (ph % 2 == 0)
				hold_req = 1'b1;
			turn_left = 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				case ($urandom_range(0, 5))
					0: s = ($urandom_range(0, 1) != 0) ? 10'h3FF : 10'h000;
					1, 2: s = SW'($urandom());
					default: begin
						near = int'(cur_tgt) + int'($urandom_range(0, 128)) - 64;
						if (near < 0)
							near = 0;
						if (near > 1023)
							near = 1023;
						s = SW'(near);
					end
				endcase
				if (turn_left == 0 && $urandom_range(0, 11) == 0)
					turn_left = int'($urandom_range(1, 6));
				if ($urandom_range(0, 9) == 0) begin
					f = SW'($urandom());
				end else if (turn_left > 0 && cur_lim != 10'h3FF) begin
					f = SW'($urandom_range(int'(cur_lim) + 1, 1023));
				end else begin
					f = SW'($urandom_range(0, int'(cur_lim)));
				end
				if (turn_left > 0)
					turn_left--;
				send_sample(s, f);
			end
			drain_results();
		end

		// long one-sided error runs walk the integral up, then down, no idling
		burst = 1'b1;
		reg_write(wfps_pkg::REG_BASE_SPEED, 32'd128);
		reg_write(wfps_pkg::REG_GAIN_P, $urandom_range(0, 63) - 32);
		reg_write(wfps_pkg::REG_GAIN_I, 32'd1);
		reg_write(wfps_pkg::REG_GAIN_D, $urandom_range(0, 63) - 32);
		reg_write(wfps_pkg::REG_FRONT_LIMIT, 32'h3FF);
		reg_write(wfps_pkg::REG_LEFT_WALL, $urandom());
		reg_write(wfps_pkg::REG_SIDE_TARGET, 32'd0);
		for (int n = 0; n < SOAK_UP; n++)
			send_sample(SW'(10'h3FF - $urandom_range(0, 3)), SW'($urandom()));
		drain_results();
		reg_write(wfps_pkg::REG_SIDE_TARGET, 32'h3FF);
		for (int n = 0; n < SOAK_DOWN; n++)
			send_sample(SW'($urandom_range(0, 3)), SW'($urandom()));
		drain_results();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending_words == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int gap;
		speed_ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				speed_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = burst ? 0 : int'($urandom_range(0, 8));
			if (gap > 0) begin
				speed_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			speed_ready <= 1'b1;
			do @(posedge clk); while (!speed_valid);
		end
	end

endmodule
